// ----- hw/rtl/oecb_pkg.sv -----
// Shared types, widths and cell-position masks for the odd/even balancing sequencer.
// No dependencies; every other file in hw/rtl imports this package.
`default_nettype none

package oecb_pkg;

    localparam int NUM_CELLS   = 15;
    localparam int GROUP_SIZE  = 5;
    localparam int MASK_W      = 15;
    localparam int IDX_W       = 4;
    localparam int MV_W        = 16;
    localparam int COUNT_W     = 9;
    localparam int PERIOD_W    = 8;
    localparam int CELL_IDX_W  = $clog2(NUM_CELLS);

    typedef enum logic
    {
        FUNC_STORE = 1'b0,
        FUNC_TICK  = 1'b1
    } func_t;

    // Bit i is set for every populated cell whose group position matches the parity.
    function automatic logic [MASK_W-1:0] position_mask(input logic want_even);
        logic [MASK_W-1:0] m;
        m = '0;
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            if (((i % GROUP_SIZE) % 2 == 1) == want_even)
            begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

    localparam logic [MASK_W-1:0] ODD_MASK  = position_mask(1'b0);
    localparam logic [MASK_W-1:0] EVEN_MASK = position_mask(1'b1);
    localparam logic [MASK_W-1:0] CELL_MASK = ODD_MASK | EVEN_MASK;

    typedef struct packed
    {
        logic [MASK_W-1:0]  mask;
        logic               enable;
        logic [COUNT_W-1:0] count;
    } bal_state_t;

    typedef struct packed
    {
        logic              tick;
        logic              start;
        logic [MASK_W-1:0] above;
    } tick_req_t;

endpackage

`default_nettype wire

// ----- hw/rtl/oecb_if.sv -----
// Valid/ready channel interfaces for the item, result and configuration ports.
// Depends on oecb_pkg for field widths.
`default_nettype none

interface oecb_in_if import oecb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              func;
    logic [IDX_W-1:0]  cell_index;
    logic [MV_W-1:0]   cell_millivolts;
    logic [MV_W-1:0]   reference_millivolts;
    logic              start_request;

    modport source (output valid, func, cell_index, cell_millivolts,
                    reference_millivolts, start_request, input ready);
    modport sink (input valid, func, cell_index, cell_millivolts,
                  reference_millivolts, start_request, output ready);
endinterface

interface oecb_out_if import oecb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MASK_W-1:0]  bleed_mask;
    logic               balancing_enabled;
    logic [COUNT_W-1:0] phase_count;

    modport source (output valid, bleed_mask, balancing_enabled, phase_count,
                    input ready);
    modport sink (input valid, bleed_mask, balancing_enabled, phase_count,
                  output ready);
endinterface

interface oecb_cfg_if import oecb_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [PERIOD_W-1:0] phase_period;

    modport source (output valid, phase_period, input ready);
    modport sink (input valid, phase_period, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/oecb_cell_store.sv -----
// Cell voltage registers and the parallel threshold comparators.
// Depends on oecb_pkg.
`default_nettype none

module oecb_cell_store import oecb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [IDX_W-1:0]  wr_index,
    input  wire logic [MV_W-1:0]   wr_millivolts,
    input  wire logic [MV_W-1:0]   reference,
    output logic      [MASK_W-1:0] above
);

    logic [MV_W-1:0] voltage_reg [NUM_CELLS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CELLS; i++)
            begin
                voltage_reg[i] <= '0;
            end
        end
        else if (wr_en && (wr_index < IDX_W'(NUM_CELLS)))
        begin
            voltage_reg[wr_index[CELL_IDX_W-1:0]] <= wr_millivolts;
        end
    end

    // Unpopulated positions never report a cell above the reference.
    always_comb
    begin
        above = '0;
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            above[i] = voltage_reg[i] > reference;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/oecb_phase_ctrl.sv -----
// Enable flag, phase counter and bleed mask, with the odd/even phase step.
// Depends on oecb_pkg.
`default_nettype none

module oecb_phase_ctrl import oecb_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tick_req_t           step,
    input  wire logic [PERIOD_W-1:0] period,
    output bal_state_t               state_next
);

    bal_state_t state_reg;

    logic [COUNT_W-1:0] p;
    logic [COUNT_W-1:0] p2;
    logic [COUNT_W-1:0] count_inc;
    logic [MASK_W-1:0]  sel;
    logic               en;

    assign p         = {1'b0, period};
    assign p2        = {period, 1'b0};
    assign count_inc = state_reg.count + COUNT_W'(1);
    assign en        = state_reg.enable | step.start;

    always_comb
    begin
        state_next = state_reg;
        sel        = '0;
        if (step.tick)
        begin
            state_next.enable = en;
            if (!en)
            begin
                state_next.mask = '0;
            end
            else if (state_reg.count == '0)
            begin
                sel              = step.above & ODD_MASK;
                state_next.mask  = sel;
                state_next.count = (sel == '0) ? p : count_inc;
            end
            else if (state_reg.count == p)
            begin
                sel              = step.above & EVEN_MASK;
                state_next.mask  = sel;
                state_next.count = (sel == '0) ? p2 : count_inc;
            end
            else if (state_reg.count == p2)
            begin
                state_next.mask   = '0;
                state_next.enable = |step.above;
                state_next.count  = '0;
            end
            else
            begin
                state_next.count = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_mask_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.mask != '0) |-> state_reg.enable)
        else $error("bleed mask set while balancing is disabled");

    a_mask_one_parity: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg.mask & ODD_MASK) == '0) || ((state_reg.mask & EVEN_MASK) == '0))
        else $error("odd and even cells bleeding together");

    a_mask_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.mask & ~CELL_MASK) == '0)
        else $error("bleed bit set on an unpopulated cell");

    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (step.tick && !step.start && !state_reg.enable)
        |=> (state_reg.mask == '0) && $stable(state_reg.count))
        else $error("disabled tick changed counter or left mask set");

endmodule

`default_nettype wire

// ----- hw/rtl/odd_even_cell_balance_sequencer_top.sv -----
// Top level of the odd/even passive balancing sequencer: input register, step logic,
// result register and the phase_period register. Depends on oecb_pkg, oecb_if,
// oecb_cell_store and oecb_phase_ctrl.
//
//  Channel  Modport   Payload                                          Moves
//  item     sink      func, cell_index, cell_millivolts,               one request per item
//                     reference_millivolts, start_request
//  result   source    bleed_mask, balancing_enabled, phase_count       one result per item
//  cfg      sink      phase_period                                     one register write
//
// An accepted request is held in the input register, then the step logic
// (fifteen comparators and the phase counter update) writes the result register.
// The result is valid from the result register; one request per cycle is
// sustained while the result side keeps taking results.
// A stalled result holds in the result register while the input register still
// takes a request; ready drops only when both registers are full.
// Reset is asynchronous and active low; it clears the stored voltages, the enable
// flag, the counter and the mask, and sets phase_period to 4. cfg is always ready.
`default_nettype none

module odd_even_cell_balance_sequencer_top import oecb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    oecb_in_if.sink   item,
    oecb_out_if.source result,
    oecb_cfg_if.sink  cfg
);

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(4);

    // Input register.
    logic              s1_valid_reg;
    logic              s1_func_reg;
    logic [IDX_W-1:0]  s1_index_reg;
    logic [MV_W-1:0]   s1_mv_reg;
    logic [MV_W-1:0]   s1_ref_reg;
    logic              s1_start_reg;

    // Result register.
    logic              out_valid_reg;
    bal_state_t        out_state_reg;

    logic [PERIOD_W-1:0] period_reg;

    logic              advance;
    logic              accept;
    logic [MASK_W-1:0] above;
    tick_req_t         step;
    bal_state_t        state_next;

    // The input register moves on whenever the result register is empty or draining.
    assign advance    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || advance;
    assign accept     = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
        end
        else if (cfg.valid)
        begin
            period_reg <= cfg.phase_period;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg  <= item.func;
            s1_index_reg <= item.cell_index;
            s1_mv_reg    <= item.cell_millivolts;
            s1_ref_reg   <= item.reference_millivolts;
            s1_start_reg <= item.start_request;
        end
    end

    oecb_cell_store u_cell_store
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (advance && (s1_func_reg == FUNC_STORE)),
        .wr_index      (s1_index_reg),
        .wr_millivolts (s1_mv_reg),
        .reference     (s1_ref_reg),
        .above         (above)
    );

    // Only a tick that actually advances out of the input register steps the state.
    assign step.tick  = advance && (s1_func_reg == FUNC_TICK);
    assign step.start = s1_start_reg;
    assign step.above = above;

    oecb_phase_ctrl u_phase_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .period     (period_reg),
        .state_next (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // A store request reports the state as it stands, which state_next already is.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_state_reg <= state_next;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.bleed_mask        = out_state_reg.mask;
    assign result.balancing_enabled = out_state_reg.enable;
    assign result.phase_count       = out_state_reg.count;

endmodule

`default_nettype wire

// ----- tb/sv/oecb_mask_checker.sv -----
// Result checker for the odd/even balancing sequencer: watches the item, result and
// cfg channels, predicts every result and compares it. Depends on oecb_pkg and oecb_if.
`timescale 1ns / 1ps

module oecb_mask_checker import oecb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    oecb_in_if        item,
    oecb_out_if       result,
    oecb_cfg_if       cfg,
    output int        mismatch_count,
    output int        outstanding,
    output int        tick_count,
    output int        store_count,
    output int        compared_count
);

    // Predicted copy of the block state.
    logic [MV_W-1:0]     cell_mv [NUM_CELLS];
    logic                enabled;
    logic [COUNT_W-1:0]  counter;
    logic [MASK_W-1:0]   bleeding;
    logic [PERIOD_W-1:0] period;

    bal_state_t expected_q[$];

    task automatic report(input string msg);
        $display("ERROR: result %0d: %s", compared_count, msg);
        mismatch_count++;
    endtask

    // Cells in the requested group-position parity whose voltage is strictly above
    // the threshold. Odd cells sit at positions 0, 2 and 4 of each group of five.
    function automatic logic [MASK_W-1:0] cells_above(input logic want_even,
                                                      input logic [MV_W-1:0] threshold);
        logic [MASK_W-1:0] m;
        m = '0;
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            if ((((i % GROUP_SIZE) & 1) == int'(want_even)) && (cell_mv[i] > threshold))
            begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

    task automatic apply_request(input func_t f, input logic [IDX_W-1:0] idx,
                                 input logic [MV_W-1:0] mv, input logic [MV_W-1:0] threshold,
                                 input logic start);
        logic [COUNT_W-1:0] p;
        logic [COUNT_W-1:0] p2;
        bal_state_t         next_out;
        p  = {1'b0, period};
        p2 = {period, 1'b0};
        if (f == FUNC_STORE)
        begin
            store_count++;
            if (idx < NUM_CELLS)
            begin
                cell_mv[idx] = mv;
            end
        end
        else
        begin
            tick_count++;
            if (start)
            begin
                enabled = 1'b1;
            end
            if (!enabled)
            begin
                bleeding = '0;
            end
            else if (counter == '0)
            begin
                bleeding = cells_above(1'b0, threshold);
                counter  = (bleeding == '0) ? p : counter + 1'b1;
            end
            else if (counter == p)
            begin
                bleeding = cells_above(1'b1, threshold);
                counter  = (bleeding == '0) ? p2 : counter + 1'b1;
            end
            else if (counter == p2)
            begin
                bleeding = '0;
                enabled  = |(cells_above(1'b0, threshold) | cells_above(1'b1, threshold));
                counter  = '0;
            end
            else
            begin
                counter = counter + 1'b1;
            end
        end
        next_out.mask   = bleeding;
        next_out.enable = enabled;
        next_out.count  = counter;
        expected_q.push_back(next_out);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CELLS; i++)
            begin
                cell_mv[i] = '0;
            end
            enabled        = 1'b0;
            counter        = '0;
            bleeding       = '0;
            period         = PERIOD_W'(4);
            mismatch_count = 0;
            tick_count     = 0;
            store_count    = 0;
            compared_count = 0;
            expected_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    report("result arrived with no request outstanding");
                end
                else
                begin
                    bal_state_t want;
                    want = expected_q.pop_front();
                    if (result.bleed_mask !== want.mask)
                    begin
                        report($sformatf("bleed_mask got 0x%04h expected 0x%04h",
                                         result.bleed_mask, want.mask));
                    end
                    if (result.balancing_enabled !== want.enable)
                    begin
                        report($sformatf("balancing_enabled got %b expected %b",
                                         result.balancing_enabled, want.enable));
                    end
                    if (result.phase_count !== want.count)
                    begin
                        report($sformatf("phase_count got %0d expected %0d",
                                         result.phase_count, want.count));
                    end
                end
                compared_count++;
            end
            if (cfg.valid && cfg.ready)
            begin
                period = cfg.phase_period;
            end
            if (item.valid && item.ready)
            begin
                apply_request(func_t'(item.func), item.cell_index, item.cell_millivolts,
                              item.reference_millivolts, item.start_request);
            end
            outstanding <= expected_q.size();
        end
    end

endmodule

// ----- tb/sv/odd_even_cell_balance_sequencer_top_tb.sv -----
// Testbench top for the odd/even balancing sequencer: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict. Depends on oecb_pkg, oecb_if,
// oecb_mask_checker and the sequencer RTL.
`timescale 1ns / 1ps

module odd_even_cell_balance_sequencer_top_tb;
    import oecb_pkg::*;

    // A quiet stretch longer than this means the block has hung. The longest
    // legitimate stretch is the deliberate result stall below plus the random gaps.
    localparam int QUIET_LIMIT  = 1000;
    localparam int LONG_HOLD    = 40;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 60;
    localparam int WRAP_TICKS   = 530;
    localparam int SETTLE_TICKS = 8;

    logic clk;
    logic rst_n;

    oecb_in_if  item_ch ();
    oecb_out_if result_ch ();
    oecb_cfg_if cfg_ch ();

    int mismatch_count;
    int outstanding;
    int tick_count;
    int store_count;
    int compared_count;

    // Handshake between the stimulus process and the result sink: every increment
    // of hold_asks makes the sink hold ready low for one long stretch.
    int hold_asks     = 0;
    int period_writes = 0;
    int quiet_cycles  = 0;
    bit sender_eager  = 1'b0;

    odd_even_cell_balance_sequencer_top DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    oecb_mask_checker u_mask_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (item_ch),
        .result         (result_ch),
        .cfg            (cfg_ch),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding),
        .tick_count     (tick_count),
        .store_count    (store_count),
        .compared_count (compared_count)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Offer one request. Unless the sender is in an eager stretch, valid may first drop
    // for a random gap. Returns at the edge that accepts it.
    task automatic send_item(input func_t f, input logic [IDX_W-1:0] idx,
                             input logic [MV_W-1:0] mv, input logic [MV_W-1:0] threshold,
                             input logic start);
        int gap;
        gap = sender_eager ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid                <= 1'b1;
        item_ch.func                 <= f;
        item_ch.cell_index           <= idx;
        item_ch.cell_millivolts      <= mv;
        item_ch.reference_millivolts <= threshold;
        item_ch.start_request        <= start;
        do
        begin
            @(posedge clk);
        end
        while (!item_ch.ready);
    endtask

    // Store requests carry random threshold and start bits, which the block must ignore.
    task automatic store_cell(input logic [IDX_W-1:0] idx, input logic [MV_W-1:0] mv);
        send_item(FUNC_STORE, idx, mv, MV_W'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // Tick requests carry a random cell index and voltage, which the block must ignore.
    task automatic tick(input logic [MV_W-1:0] threshold, input logic start);
        send_item(FUNC_TICK, IDX_W'($urandom), MV_W'($urandom), threshold, start);
    endtask

    // Stop offering and wait until the checker has seen every predicted result.
    // The first edge lets the checker count the request accepted last.
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    // The register is only written while the block is idle, so callers drain first.
    task automatic write_period(input logic [PERIOD_W-1:0] value);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.phase_period <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        period_writes++;
    endtask

    // Result sink. Each result waits a random gap, except in eager stretches that
    // are redrawn every 64 results, and except when a long hold has been asked for.
    initial
    begin : result_sink
        int gap;
        int taken;
        int hold_done;
        bit recv_eager;
        result_ch.ready <= 1'b0;
        taken      = 0;
        hold_done  = 0;
        recv_eager = 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (taken % 64 == 0)
            begin
                recv_eager = ($urandom_range(0, 3) == 0);
            end
            if (hold_done != hold_asks)
            begin
                gap = LONG_HOLD;
                hold_done++;
            end
            else
            begin
                gap = recv_eager ? 0 : $urandom_range(0, 4);
            end
            if (gap != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!result_ch.valid);
            taken++;
        end
    end

    // Watchdog: any accepted request, result or register write restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("ERROR: no channel activity for %0d cycles", QUIET_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int r;
        logic [PERIOD_W-1:0] per;

        // Every input of the block is driven to a known value from time zero.
        rst_n                        <= 1'b0;
        item_ch.valid                <= 1'b0;
        item_ch.func                 <= FUNC_STORE;
        item_ch.cell_index           <= '0;
        item_ch.cell_millivolts      <= '0;
        item_ch.reference_millivolts <= '0;
        item_ch.start_request        <= 1'b0;
        cfg_ch.valid                 <= 1'b0;
        cfg_ch.phase_period          <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with phase_period at its reset value of 4. A tick straight
        // out of reset must show a disabled block with an empty mask.
        tick(MV_W'(0), 1'b0);
        // The extremes of the voltage range, plus a store to the one index past the
        // last cell, which must leave every stored voltage untouched.
        store_cell(IDX_W'(0), 16'hFFFF);
        store_cell(IDX_W'(14), 16'h0000);
        store_cell(IDX_W'(NUM_CELLS), 16'h1234);
        store_cell(IDX_W'(5), MV_W'(4100));
        store_cell(IDX_W'(6), MV_W'(3900));
        // A full balancing round: the odd phase selects cells 0 and 5, the even phase
        // finds nothing above 4000 and jumps to twice the period, and the round end
        // keeps balancing enabled because cells are still above the threshold.
        tick(MV_W'(4000), 1'b1);
        repeat (5) tick(MV_W'(4000), 1'b0);
        // With the threshold at full scale nothing is above it, so both phases are
        // skipped and the round end turns balancing off.
        repeat (3) tick(16'hFFFF, 1'b0);
        tick(MV_W'(0), 1'b0);
        // A voltage equal to the threshold does not count as above it.
        store_cell(IDX_W'(5), MV_W'(4000));
        tick(MV_W'(4000), 1'b1);
        store_cell(IDX_W'(0), 16'h0000);
        tick(MV_W'(0), 1'b0);
        tick(MV_W'(0), 1'b1);
        drain_results();

        // Random phases, each run at its own phase_period with the block idle when the
        // register is written. The first three settings are a period of one, the largest
        // period and a zero period. Phase three also asks the result sink for one long stall,
        // so the block fills up and holds off new requests.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       per = PERIOD_W'(1);
                1:       per = PERIOD_W'(255);
                2:       per = PERIOD_W'(0);
                3:       per = PERIOD_W'(4);
                default: per = ($urandom_range(0, 3) == 0) ? PERIOD_W'($urandom)
                                                           : PERIOD_W'($urandom_range(1, 12));
            endcase
            write_period(per);
            if (ph == 3)
            begin
                hold_asks++;
            end
            sender_eager = ($urandom_range(0, 3) == 0);
            // Most requests keep voltages and thresholds in one narrow band, so that
            // the masks are neither always full nor always empty. A few use the full
            // range, and a few stores go to the index past the last cell.
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 30)
                begin
                    send_item(FUNC_STORE,
                              (r < 3) ? IDX_W'(NUM_CELLS) : IDX_W'($urandom_range(0, 14)),
                              (r < 8) ? MV_W'($urandom) : MV_W'($urandom_range(3000, 4200)),
                              MV_W'($urandom), 1'($urandom_range(0, 1)));
                end
                else
                begin
                    send_item(FUNC_TICK, IDX_W'($urandom), MV_W'($urandom),
                              (r < 38) ? MV_W'($urandom) : MV_W'($urandom_range(3000, 4200)),
                              ($urandom_range(0, 9) == 0));
                end
            end
            drain_results();
        end

        // With a zero period and a cell above the threshold, the odd phase never ends:
        // the counter runs all the way up and wraps through 511 back to 0.
        write_period(PERIOD_W'(0));
        sender_eager = 1'b0;
        store_cell(IDX_W'(0), 16'hFFFF);
        for (int n = 0; n < WRAP_TICKS; n++)
        begin
            tick(MV_W'($urandom_range(0, 2999)), 1'($urandom_range(0, 1)));
        end
        drain_results();

        // Leave the register back at its reset value and let the pipeline settle.
        write_period(PERIOD_W'(4));
        repeat (SETTLE_TICKS) @(posedge clk);

        $display("Run covered %0d requests (%0d ticks, %0d stores) and %0d compared results.",
                 tick_count + store_count, tick_count, store_count, compared_count);
        $display("phase_period took %0d settings including 0, 1 and 255, with a counter wrap.",
                 period_writes);
        if (mismatch_count == 0 && outstanding == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
